// File: rtl/fmta_pkg.sv
// ----------------------------------------------------------------------------
// fmta_pkg
// Types, widths, register codes and unit tables for the flow meter block.
// ----------------------------------------------------------------------------
package fmta_pkg;

  localparam int SAMPLE_W  = 16;  // pulse count of one tick
  localparam int WINLEN_W  = 4;
  localparam int PPU_W     = 16;
  localparam int UNIT_W    = 2;
  localparam int FLOW_W    = 38;
  localparam int VOL_W     = 54;
  localparam int K_W       = 22;  // flow constant width
  localparam int F_W       = 14;  // volume factor width

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WINDOW  = 10;
  localparam int DEF_COUNT_WIDTH = 40;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PPU        = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNIT_MODE  = 2'd2;

  // unit codes
  localparam logic [UNIT_W-1:0] UNIT_LITER  = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_GALLON = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_CUBIC  = 2'd2;

  localparam logic [WINLEN_W-1:0] RST_WINDOW_LEN = 4'd4;
  localparam logic [PPU_W-1:0]    RST_PPU        = 16'd1000;
  localparam logic [UNIT_W-1:0]   RST_UNIT_MODE  = UNIT_LITER;

  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] pulse_count;
    logic                clear_total;
  } in_item_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow_rate;
    logic [VOL_W-1:0]  total_volume;
    logic [VOL_W-1:0]  partial_volume;
    logic              activity;
  } out_item_t;

  // flow constant per unit, unused code gives zero
  function automatic logic [K_W-1:0] flow_k(input logic [UNIT_W-1:0] mode);
    logic [K_W-1:0] k;
    unique case (mode)
      UNIT_LITER:  k = 22'd2400000;
      UNIT_GALLON: k = 22'd634013;
      UNIT_CUBIC:  k = 22'd144000;
      default:     k = '0;
    endcase
    return k;
  endfunction

  // volume factor per unit, unused code gives zero
  function automatic logic [F_W-1:0] vol_f(input logic [UNIT_W-1:0] mode);
    logic [F_W-1:0] f;
    unique case (mode)
      UNIT_LITER:  f = 14'd10000;
      UNIT_GALLON: f = 14'd2642;
      UNIT_CUBIC:  f = 14'd10;
      default:     f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/fmta_scan.sv
// ----------------------------------------------------------------------------
// fmta_scan
// Sample ring memory and sequential window scan for the trimmed sum.
// ----------------------------------------------------------------------------
module fmta_scan import fmta_pkg::*; #(
  parameter int  MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int AW         = $clog2(MAX_WINDOW),
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                start,
  input  logic [WIN_W-1:0]    win_n,
  output logic                done,
  output logic [SUM_W-1:0]    sum,
  output logic [WIN_W-1:0]    div_n
);

  logic [SAMPLE_W-1:0]   mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ent_vld_r;

  logic                issue_r;
  logic [WIN_W-1:0]    iss_r;
  logic [AW-1:0]       rd_addr;
  logic                rd_vld_r;
  logic                rd_last_r;
  logic                rd_ok_r;
  logic [AW-1:0]       rd_idx_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SAMPLE_W-1:0] v;

  logic [SUM_W-1:0]    tot_r;
  logic [SAMPLE_W-1:0] vmax_r;
  logic [SAMPLE_W-1:0] vmin_r;
  logic [AW-1:0]       imax_r;
  logic [AW-1:0]       imin_r;
  logic                fin_r;
  logic                done_r;
  logic [SUM_W-1:0]    sum_r;
  logic [WIN_W-1:0]    div_r;

  assign rd_addr = iss_r[AW-1:0];
  assign v       = rd_ok_r ? rd_data_r : '0;  // never written reads as zero

  // ring storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue_r) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
      if (issue_r) begin
        rd_ok_r <= ent_vld_r[rd_addr];
      end
    end
  end

  // read issue and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      iss_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      fin_r     <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (start) begin
        issue_r <= 1'b1;
        iss_r   <= '0;
      end else if (issue_r) begin
        iss_r <= iss_r + 1'b1;
        if (iss_r == win_n - 1'b1) begin
          issue_r <= 1'b0;
        end
      end
      rd_vld_r  <= issue_r;
      rd_last_r <= issue_r && (iss_r == win_n - 1'b1);
      fin_r     <= rd_vld_r && rd_last_r;
      done_r    <= fin_r;
    end
  end

  // running sum, first-found max and min
  always_ff @(posedge clk) begin
    if (issue_r) begin
      rd_idx_r <= rd_addr;
    end
    if (rd_vld_r) begin
      if (rd_idx_r == '0) begin
        tot_r  <= SUM_W'(v);
        vmax_r <= v;
        vmin_r <= v;
        imax_r <= '0;
        imin_r <= '0;
      end else begin
        tot_r <= tot_r + SUM_W'(v);
        if (v > vmax_r) begin
          vmax_r <= v;
          imax_r <= rd_idx_r;
        end
        if (v < vmin_r) begin
          vmin_r <= v;
          imin_r <= rd_idx_r;
        end
      end
    end
    if (fin_r) begin
      if (win_n < WIN_W'(3)) begin
        sum_r <= tot_r;
        div_r <= win_n;
      end else if (imax_r == imin_r) begin
        sum_r <= tot_r - SUM_W'(vmax_r);
        div_r <= win_n - WIN_W'(1);
      end else begin
        sum_r <= tot_r - SUM_W'(vmax_r) - SUM_W'(vmin_r);
        div_r <= win_n - WIN_W'(2);
      end
    end
  end

  assign done  = done_r;
  assign sum   = sum_r;
  assign div_n = div_r;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> vmin_r <= vmax_r)
    else $error("scan minimum above maximum");

  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !issue_r && !rd_vld_r && !fin_r)
    else $error("scan restarted while busy");

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(fin_r))
    else $error("scan done without finish");

endmodule

// File: rtl/fmta_div.sv
// ----------------------------------------------------------------------------
// fmta_div
// Shared radix-4 restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module fmta_div #(
  parameter int DVD_W = 54,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int DQ_W  = DVD_W + (DVD_W % 2);
  localparam int STEPS = DQ_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DQ_W-1:0]  q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   s1;
  logic [DVS_W:0]   s2;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] rem,
                                              input logic             b,
                                              input logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic [DVS_W:0] r;
    logic           ge;
    t  = {rem, b};
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {ge, r[DVS_W-1:0]};
  endfunction

  assign s1 = div_step(rem_r, q_r[DQ_W-1], dvs_r);
  assign s2 = div_step(s1[DVS_W-1:0], q_r[DQ_W-2], dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= DQ_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DQ_W-3:0], s1[DVS_W], s2[DVS_W]};
      rem_r <= s2[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r[DVD_W-1:0];

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r && !busy_r)
    else $error("divider done held");

endmodule

// File: rtl/flow_meter_trimmed_average_top.sv
// ----------------------------------------------------------------------------
// flow_meter_trimmed_average_top
// Pulse flow meter: trimmed moving average flow rate and scaled volumes.
// ----------------------------------------------------------------------------
//
//  channel  signals                          dir  meaning
//  -------  -------------------------------  ---  ---------------------------
//  in       in_valid, in_stall, in_data      in   one 250 ms tick item
//  out      out_valid, out_stall, out_data   out  flow rate and volumes item
//  cfg      cfg_valid, cfg_ready, cfg_addr,  in   register write (window_len,
//           cfg_data                              pulses_per_unit, unit_mode)
//
//  the shared divider, with a dividend 54 bits wide at default parameters, is
//  run three times per item, once for the flow rate and once per volume
//  in_stall is high from acceptance until the result is in the output
//  register; a result waiting on out_stall does not block the next item, but
//  that item's result waits in the done state until the register frees up
//  reset (synchronous, rst_n low) clears counters, ring index, ring valid
//  bits and restores the register defaults; cfg_ready is always high
//
module flow_meter_trimmed_average_top import fmta_pkg::*; #(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int OPA_W = (SUM_W > COUNT_WIDTH) ? SUM_W : COUNT_WIDTH;
  localparam int DW    = (SUM_W + K_W > COUNT_WIDTH + F_W) ? (SUM_W + K_W)
                                                           : (COUNT_WIDTH + F_W);
  localparam int DVS_W = WIN_W + PPU_W;
  localparam int QW    = (DW > VOL_W) ? DW : VOL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // which quotient is being worked on
  localparam logic [1:0] PH_FLOW  = 2'd0;
  localparam logic [1:0] PH_TOTAL = 2'd1;
  localparam logic [1:0] PH_PART  = 2'd2;

  // configuration registers
  logic [WINLEN_W-1:0] win_len_r;
  logic [PPU_W-1:0]    ppu_r;
  logic [UNIT_W-1:0]   unit_r;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;

  logic [COUNT_WIDTH-1:0] tot_r, tot_nxt;
  logic [COUNT_WIDTH-1:0] part_r, part_nxt;
  logic [COUNT_WIDTH-1:0] tot_base;
  logic [COUNT_WIDTH:0]   tot_sum;
  logic [COUNT_WIDTH:0]   part_sum;
  logic [WIN_W-1:0]       ri_r;
  logic                   act_r;

  logic [FLOW_W-1:0] flow_r;
  logic [VOL_W-1:0]  tvol_r;
  logic [VOL_W-1:0]  pvol_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_acc;
  logic              out_free;
  logic              idx_ok;
  logic [WIN_W-1:0]  n_eff;
  logic [PPU_W-1:0]  ppu_eff;

  logic              scan_done;
  logic [SUM_W-1:0]  scan_sum;
  logic [WIN_W-1:0]  scan_div;

  logic [OPA_W-1:0]     op_a;
  logic [K_W-1:0]       op_b;
  logic [OPA_W+K_W-1:0] mul_prod;
  logic [DVS_W-1:0]     dvs_flow;
  logic [DVS_W-1:0]     dvs_in;
  logic                 div_start;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic [QW-1:0]        quo_x;
  logic [VOL_W-1:0]     vol_sat;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // window length clamped to 1..MAX_WINDOW, zero calibration used as one
  always_comb begin
    if (win_len_r == '0) begin
      n_eff = WIN_W'(1);
    end else if (32'(win_len_r) > MAX_WINDOW) begin
      n_eff = WIN_W'(MAX_WINDOW);
    end else begin
      n_eff = WIN_W'(win_len_r);
    end
  end
  assign ppu_eff = (ppu_r == '0) ? PPU_W'(1) : ppu_r;
  assign idx_ok  = (ri_r < n_eff);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= RST_WINDOW_LEN;
      ppu_r     <= RST_PPU;
      unit_r    <= RST_UNIT_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_WINDOW_LEN: win_len_r <= cfg_data[WINLEN_W-1:0];
        REG_PPU:        ppu_r     <= cfg_data[PPU_W-1:0];
        REG_UNIT_MODE:  unit_r    <= cfg_data[UNIT_W-1:0];
        default:        ;  // unused index, write dropped
      endcase
    end
  end

  // saturating pulse counters, total cleared first on request
  assign tot_base = in_data.clear_total ? '0 : tot_r;
  assign tot_sum  = {1'b0, tot_base} + (COUNT_WIDTH + 1)'(in_data.pulse_count);
  assign part_sum = {1'b0, part_r} + (COUNT_WIDTH + 1)'(in_data.pulse_count);
  assign tot_nxt  = tot_sum[COUNT_WIDTH]  ? '1 : tot_sum[COUNT_WIDTH-1:0];
  assign part_nxt = part_sum[COUNT_WIDTH] ? '1 : part_sum[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r  <= '0;
      part_r <= '0;
      ri_r   <= '0;
    end else begin
      if (in_acc) begin
        tot_r  <= tot_nxt;
        part_r <= part_nxt;
        ri_r   <= ri_r + 1'b1;
      end else if (state_r != S_IDLE && !idx_ok) begin
        // wrap the ring index one subtraction per cycle while busy
        ri_r <= ri_r - n_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= (in_data.pulse_count != '0);
    end
  end

  // ring memory and window scan
  fmta_scan #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_addr (ri_r[AW-1:0]),
    .wr_data (in_data.pulse_count),
    .start   (in_acc),
    .win_n   (n_eff),
    .done    (scan_done),
    .sum     (scan_sum),
    .div_n   (scan_div)
  );

  // operand select for the one multiplier feeding the divider
  always_comb begin
    if (ph_r == PH_FLOW) begin
      op_a = OPA_W'(scan_sum);
      op_b = flow_k(unit_r);
    end else if (ph_r == PH_TOTAL) begin
      op_a = OPA_W'(tot_r);
      op_b = K_W'(vol_f(unit_r));
    end else begin
      op_a = OPA_W'(part_r);
      op_b = K_W'(vol_f(unit_r));
    end
  end
  assign mul_prod  = op_a * op_b;
  assign dvs_flow  = DVS_W'(scan_div) * DVS_W'(ppu_eff);
  assign dvs_in    = (ph_r == PH_FLOW) ? dvs_flow : DVS_W'(ppu_eff);
  assign div_start = (state_r == S_MUL);

  fmta_div #(
    .DVD_W (DW),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod[DW-1:0]),
    .divisor  (dvs_in),
    .done     (div_done),
    .quotient (div_quo)
  );

  // flow keeps the low bits, volumes saturate
  assign quo_x   = QW'(div_quo);
  assign vol_sat = (quo_x > QW'(VOL_MAX)) ? VOL_MAX : quo_x[VOL_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
          ph_nxt    = PH_FLOW;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (ph_r == PH_PART) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL;
            ph_nxt    = ph_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free && idx_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_FLOW;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // quotient capture
  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_done) begin
      unique case (ph_r)
        PH_FLOW:  flow_r <= quo_x[FLOW_W-1:0];
        PH_TOTAL: tvol_r <= vol_sat;
        default:  pvol_r <= vol_sat;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free && idx_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free && idx_ok) begin
      out_data_r.flow_rate      <= flow_r;
      out_data_r.total_volume   <= tvol_r;
      out_data_r.partial_volume <= pvol_r;
      out_data_r.activity       <= act_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result shown outside done state");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.clear_total) |=> tot_r >= $past(tot_r))
    else $error("total counter went down without clear");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

endmodule

// File: test/tb_flow_meter_trimmed_average_top.sv
// ----------------------------------------------------------------------------
// tb_flow_meter_trimmed_average_top
// Self-checking bench for the pulse flow meter. Tick items go in from a
// queue through a clocked driver, and a clocked monitor checks each result
// against a cycle-free model of the trimmed-mean window, the saturating
// counters and the unit scaling. Settings are changed only while the block
// is idle.
// ----------------------------------------------------------------------------
module tb_flow_meter_trimmed_average_top;
  import fmta_pkg::*;

  localparam int MAX_WIN      = DEF_MAX_WINDOW;
  localparam int LIMIT_CYCLES = 400000;  // timeout, many times the slowest clean run
  localparam int HOLD_CYCLES  = 700;     // long receiver hold-off, several items deep
  localparam int END_WAIT     = 150;     // wait before the final result line

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

  localparam bit [63:0] CNT_MAX   = (64'd1 << DEF_COUNT_WIDTH) - 64'd1;
  localparam bit [63:0] VOL_LIMIT = (64'd1 << VOL_W) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // stimulus and expected readings
  in_item_t pending_ticks[$];
  out_item_t expected_readings[$];

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned cycle_cnt = 0;

  // model state
  logic [SAMPLE_W-1:0] ring_mem[MAX_WIN];
  int unsigned ring_pos;
  bit [63:0] tot_cnt;
  bit [63:0] part_cnt;
  logic [WINLEN_W-1:0] win_reg;
  logic [PPU_W-1:0] ppu_reg;
  logic [UNIT_W-1:0] unit_reg;

  flow_meter_trimmed_average_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of one tick
  // ---------------------------------------------------------------------------

  function automatic bit [63:0] sat_count(input bit [63:0] acc, input bit [63:0] cnt);
    bit [63:0] s;
    s = acc + cnt;
    return (s > CNT_MAX) ? CNT_MAX : s;
  endfunction

  function automatic logic [VOL_W-1:0] scale_volume(input bit [63:0] pulses,
                                                   input bit [63:0] factor,
                                                   input bit [63:0] ppu);
    bit [63:0] v;
    v = (pulses * factor) / ppu;
    if (v > VOL_LIMIT) begin
      v = VOL_LIMIT;
    end
    return v[VOL_W-1:0];
  endfunction

  function automatic out_item_t predict_reading(input in_item_t t);
    int unsigned n;
    int unsigned imax;
    int unsigned imin;
    logic [SAMPLE_W-1:0] vmax;
    logic [SAMPLE_W-1:0] vmin;
    bit [63:0] ppu;
    bit [63:0] sum;
    bit [63:0] dvs;
    bit [63:0] kf;
    bit [63:0] vf;
    bit [63:0] flow;
    out_item_t r;

    // out-of-range window lengths clamp to 1..MAX_WIN, zero calibration acts as 1
    n = 32'(win_reg);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_WIN) begin
      n = MAX_WIN;
    end
    ppu = (ppu_reg == '0) ? 64'd1 : 64'(ppu_reg);

    if (t.clear_total) begin
      tot_cnt = '0;
    end
    tot_cnt = sat_count(tot_cnt, 64'(t.pulse_count));
    part_cnt = sat_count(part_cnt, 64'(t.pulse_count));

    // after a window shrink the slot may sit outside the window
    if (ring_pos < MAX_WIN) begin
      ring_mem[ring_pos] = t.pulse_count;
    end
    ring_pos = (ring_pos + 1) % n;

    // first-found extremes
    imax = 0;
    imin = 0;
    vmax = ring_mem[0];
    vmin = ring_mem[0];
    for (int unsigned i = 1; i < n; i++) begin
      if (ring_mem[i] > vmax) begin
        vmax = ring_mem[i];
        imax = i;
      end
      if (ring_mem[i] < vmin) begin
        vmin = ring_mem[i];
        imin = i;
      end
    end
    sum = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (n < 3 || (i != imax && i != imin)) begin
        sum += 64'(ring_mem[i]);
      end
    end
    if (n < 3) begin
      dvs = 64'(n);
    end else if (imin == imax) begin
      dvs = 64'(n - 1);
    end else begin
      dvs = 64'(n - 2);
    end

    // unused unit code scales everything to zero
    case (unit_reg)
      UNIT_LITER: begin
        kf = 64'd2400000;
        vf = 64'd10000;
      end
      UNIT_GALLON: begin
        kf = 64'd634013;
        vf = 64'd2642;
      end
      UNIT_CUBIC: begin
        kf = 64'd144000;
        vf = 64'd10;
      end
      default: begin
        kf = '0;
        vf = '0;
      end
    endcase

    flow = (sum * kf) / (dvs * ppu);
    r.flow_rate = flow[FLOW_W-1:0];
    r.total_volume = scale_volume(tot_cnt, vf, ppu);
    r.partial_volume = scale_volume(part_cnt, vf, ppu);
    r.activity = (t.pulse_count != '0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending ticks, holds the item while stalled
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(in_data));
      end
      if (in_valid && in_stall) begin
        // stalled item stays put
      end else if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    err_cnt++;
    $display("[%0t] error: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", res_cnt));
      end else begin
        want = expected_readings.pop_front();
        if (out_data.flow_rate !== want.flow_rate) begin
          report_error($sformatf("result %0d flow_rate got %0d expected %0d",
                                 res_cnt, out_data.flow_rate, want.flow_rate));
        end
        if (out_data.total_volume !== want.total_volume) begin
          report_error($sformatf("result %0d total_volume got %0d expected %0d",
                                 res_cnt, out_data.total_volume, want.total_volume));
        end
        if (out_data.partial_volume !== want.partial_volume) begin
          report_error($sformatf("result %0d partial_volume got %0d expected %0d",
                                 res_cnt, out_data.partial_volume, want.partial_volume));
        end
        if (out_data.activity !== want.activity) begin
          report_error($sformatf("result %0d activity got %b expected %b",
                                 res_cnt, out_data.activity, want.activity));
        end
      end
      res_cnt++;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // long receiver hold-off, loaded once on request and counted down here
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one register write; the model picks up the new value at the same time
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_LEN: win_reg = val[WINLEN_W-1:0];
      REG_PPU:        ppu_reg = val;
      REG_UNIT_MODE:  unit_reg = val[UNIT_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every item went in and every result came out
  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  function automatic void queue_tick(input logic [SAMPLE_W-1:0] cnt, input logic clr);
    in_item_t t;
    t.pulse_count = cnt;
    t.clear_total = clr;
    pending_ticks.push_back(t);
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t t;
    case ($urandom_range(7))
      0:       t.pulse_count = '0;
      1:       t.pulse_count = '1;
      2, 3:    t.pulse_count = SAMPLE_W'($urandom_range(60));
      default: t.pulse_count = SAMPLE_W'($urandom);
    endcase
    t.clear_total = ($urandom_range(9) == 0);
    return t;
  endfunction

  // random ticks, with the odd run of equal counts so max and min coincide
  function automatic void queue_random(input int count);
    in_item_t t;
    int run;
    int left;
    left = count;
    while (left > 0) begin
      t = rand_tick();
      run = 1;
      if ($urandom_range(7) == 0) begin
        run = int'($urandom_range(12, 3));
        t.clear_total = 1'b0;
      end
      repeat (run) pending_ticks.push_back(t);
      left -= run;
    end
  endfunction

  // random setting, extremes and out-of-range codes weighted in
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] val;
    if ($urandom_range(2) != 0) begin
      val = CFG_DATA_W'($urandom);
      case ($urandom_range(9))
        0:       val[WINLEN_W-1:0] = '0;
        1:       val[WINLEN_W-1:0] = WINLEN_W'($urandom_range(15, MAX_WIN + 1));
        2:       val[WINLEN_W-1:0] = WINLEN_W'(MAX_WIN);
        3:       val[WINLEN_W-1:0] = WINLEN_W'(1);
        default: val[WINLEN_W-1:0] = WINLEN_W'($urandom_range(MAX_WIN, 1));
      endcase
      write_reg(REG_WINDOW_LEN, val);
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(7))
        0:       val = '0;
        1:       val = CFG_DATA_W'(1);
        2:       val = '1;
        3, 4:    val = CFG_DATA_W'($urandom_range(5000, 1));
        default: val = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_PPU, val);
    end
    if ($urandom_range(2) != 0) begin
      val = CFG_DATA_W'($urandom);
      if ($urandom_range(5) == 0) begin
        val[UNIT_W-1:0] = 2'd3;
      end else begin
        val[UNIT_W-1:0] = UNIT_W'($urandom_range(2));
      end
      write_reg(REG_UNIT_MODE, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // model reset state
    for (int i = 0; i < MAX_WIN; i++) begin
      ring_mem[i] = '0;
    end
    ring_pos = 0;
    tot_cnt = '0;
    part_cnt = '0;
    win_reg = RST_WINDOW_LEN;
    ppu_reg = RST_PPU;
    unit_reg = RST_UNIT_MODE;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: field extremes, clear flag, bit patterns
    queue_tick(16'h0000, 1'b0);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'hFFFF, 1'b1);
    queue_tick(16'h0000, 1'b1);
    queue_tick(16'h0001, 1'b0);
    queue_tick(16'hAAAA, 1'b0);
    queue_tick(16'h5555, 1'b1);
    drain();

    // full window in gallons, one pulse per unit; index lands on slot 7
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(MAX_WIN));
    write_reg(REG_UNIT_MODE, {14'h0, UNIT_GALLON});
    write_reg(REG_PPU, 16'd1);
    repeat (7) pending_ticks.push_back(rand_tick());
    drain();

    // shrink the window below the index, cubic meters, largest calibration
    write_reg(REG_WINDOW_LEN, 16'd3);
    write_reg(REG_UNIT_MODE, {14'h0, UNIT_CUBIC});
    write_reg(REG_PPU, 16'hFFFF);
    queue_tick(16'd300, 1'b0);
    queue_tick(16'd7, 1'b0);
    drain();

    // zero window length, zero calibration, unused unit code
    write_reg(REG_WINDOW_LEN, 16'd0);
    write_reg(REG_PPU, 16'd0);
    write_reg(REG_UNIT_MODE, 16'd3);
    queue_tick(16'd1234, 1'b0);
    queue_tick(16'd0, 1'b0);
    drain();

    // oversized window length, liters, top flow reading
    write_reg(REG_WINDOW_LEN, 16'hFFFF);
    write_reg(REG_UNIT_MODE, {14'h0, UNIT_LITER});
    write_reg(REG_PPU, 16'd1);
    repeat (3) queue_tick(16'hFFFF, 1'b0);
    drain();

    // two-sample window, plus a write to the empty index
    write_reg(REG_WINDOW_LEN, 16'd2);
    write_reg(REG_NONE, 16'hFFFF);
    queue_tick(16'd10, 1'b0);
    queue_tick(16'd20, 1'b1);
    drain();

    // random part: three idling patterns, settings changed between segments
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        random_setup();
        queue_random(30);
        if (ph == 2 && seg == 0) begin
          // receiver backs off while ticks keep coming, block fills and stalls
          @(posedge clk);
          hold_go <= 1'b1;
        end
        drain();
      end
    end

    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
